>>> rtl/mvm_pkg.sv
// Shared constants and types for the matrix-vector multiply core.
// Used by mvm_ctrl, mvm_dp and matrix_vector_multiply_core; no dependencies.
package mvm_pkg;

  // Default sizes of the stores and the element width.
  localparam int MAX_ROWS_DEF   = 16;
  localparam int MAX_COLS_DEF   = 16;
  localparam int ELEM_WIDTH_DEF = 16;

  // Fixed field widths of the ports.
  localparam int FUNC_W    = 2;
  localparam int IDX_IN_W  = 4;
  localparam int VALUE_W   = 16;
  localparam int ROW_OUT_W = 4;
  localparam int SUM_W     = 36;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;
  // Width used to compare register values and indexes against the maximum sizes.
  localparam int CMP_W     = 8;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_WR_MAT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_VEC  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEC_LEN  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_mat;     // write value into the matrix store
    logic wr_vec;     // write value into the vector store
    logic rd_valid;   // a read/MAC token is issued this cycle
    logic rd_first;   // first column of a row: restart the accumulator
    logic rd_last_col;// last column of a row: emit the row sum
    logic rd_last_row;// last row of the computation
    logic rd_err;     // token carries a size error result
  } cmd_t;

  // Flags that travel with a token down the datapath pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last_col;
    logic last_row;
    logic err;
  } tag_t;

endpackage

>>> rtl/matrix_vector_multiply_core.sv
// Matrix-vector multiply core: stores a matrix and a vector of signed Q8.8
// elements and streams out one exact Q20.16 dot product per matrix row.
// Write items leave busy low; a compute item holds busy while it walks the
// rows and columns, one multiply-accumulate per cycle through the single
// multiplier, and each row sum is strobed once its last column is summed; a
// size error result does not raise busy. Synchronous active-high reset clears
// control state and sets all three registers to one; results cannot be stalled.
module matrix_vector_multiply_core
  import mvm_pkg::*;
#(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Item command port. An item is taken when start is high and busy is low.
  input  logic                      start,
  output logic                      busy,
  input  logic [FUNC_W-1:0]         func,
  input  logic [IDX_IN_W-1:0]       row,
  input  logic [IDX_IN_W-1:0]       col,
  input  logic signed [VALUE_W-1:0] value,
  // Result port. Each result is valid for the single cycle in which strobe is high.
  output logic                      strobe,
  output logic [ROW_OUT_W-1:0]      row_index,
  output logic signed [SUM_W-1:0]   sum,
  output logic                      last,
  output logic                      size_error,
  // Configuration write channel.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // The controller decodes items, holds the configuration registers and
  // walks the rows and columns; the datapath owns the stores and the MAC.
  cmd_t              cmd;
  logic [RIDX_W-1:0] wr_row;
  logic [CIDX_W-1:0] wr_col;
  logic [RIDX_W-1:0] rd_row;
  logic [CIDX_W-1:0] rd_col;

  mvm_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .row       (row),
    .col       (col),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .wr_row    (wr_row),
    .wr_col    (wr_col),
    .rd_row    (rd_row),
    .rd_col    (rd_col)
  );

  // Every token, including a size error token, passes the same three stages,
  // so results leave in the order in which their items were accepted.
  mvm_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .wr_row     (wr_row),
    .wr_col     (wr_col),
    .rd_row     (rd_row),
    .rd_col     (rd_col),
    .value      (value),
    .strobe     (strobe),
    .row_index  (row_index),
    .sum        (sum),
    .last       (last),
    .size_error (size_error)
  );

endmodule

>>> rtl/mvm_ctrl.sv
// Controller for the matrix-vector multiply core: configuration registers,
// item decode and the row/column sequencer. Depends on mvm_pkg.
module mvm_ctrl
  import mvm_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [FUNC_W-1:0]    func,
  input  logic [IDX_IN_W-1:0]  row,
  input  logic [IDX_IN_W-1:0]  col,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cmd_t                 cmd,
  output logic [RIDX_W-1:0]    wr_row,
  output logic [CIDX_W-1:0]    wr_col,
  output logic [RIDX_W-1:0]    rd_row,
  output logic [CIDX_W-1:0]    rd_col
);

  localparam int CW_R = $clog2(MAX_ROWS + 1);
  localparam int CW_C = $clog2(MAX_COLS + 1);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  logic [0:0]       state;
  logic [CFG_W-1:0] num_rows;
  logic [CFG_W-1:0] num_cols;
  logic [CFG_W-1:0] vector_length;
  logic [CW_R-1:0]  nr_q;
  logic [CW_C-1:0]  nc_q;
  logic [RIDX_W-1:0] row_cnt;
  logic [CIDX_W-1:0] col_cnt;
  logic             err_tok;

  logic            accept;
  logic            row_ok;
  logic            col_ok;
  logic [CW_R-1:0] nr_clamp;
  logic [CW_C-1:0] nc_clamp;
  logic [CW_C-1:0] vl_clamp;
  logic            last_col;
  logic            last_row;

  assign cfg_ready = 1'b1;
  assign busy      = (state == ST_RUN);
  assign accept    = start && !busy;

  // Registers are clamped on use: zero counts as one, larger values as the maximum.
  always_comb begin
    if (num_rows == '0) begin
      nr_clamp = CW_R'(1);
    end else if (CMP_W'(num_rows) > CMP_W'(MAX_ROWS)) begin
      nr_clamp = CW_R'(MAX_ROWS);
    end else begin
      nr_clamp = CW_R'(num_rows);
    end
    if (num_cols == '0) begin
      nc_clamp = CW_C'(1);
    end else if (CMP_W'(num_cols) > CMP_W'(MAX_COLS)) begin
      nc_clamp = CW_C'(MAX_COLS);
    end else begin
      nc_clamp = CW_C'(num_cols);
    end
    if (vector_length == '0) begin
      vl_clamp = CW_C'(1);
    end else if (CMP_W'(vector_length) > CMP_W'(MAX_COLS)) begin
      vl_clamp = CW_C'(MAX_COLS);
    end else begin
      vl_clamp = CW_C'(vector_length);
    end
  end

  assign row_ok = CMP_W'(row) < CMP_W'(MAX_ROWS);
  assign col_ok = CMP_W'(col) < CMP_W'(MAX_COLS);
  assign wr_row = RIDX_W'(row);
  assign wr_col = CIDX_W'(col);

  assign last_col = (CW_C'(col_cnt) == nc_q - CW_C'(1));
  assign last_row = (CW_R'(row_cnt) == nr_q - CW_R'(1));
  assign rd_row   = row_cnt;
  assign rd_col   = col_cnt;

  always_comb begin
    cmd.wr_mat      = 1'b0;
    cmd.wr_vec      = 1'b0;
    if (accept) begin
      case (func)
        FUNC_WR_MAT: cmd.wr_mat = row_ok && col_ok;
        FUNC_WR_VEC: cmd.wr_vec = col_ok;
        default: ;
      endcase
    end
    cmd.rd_valid    = (state == ST_RUN) || err_tok;
    cmd.rd_err      = err_tok;
    cmd.rd_first    = (col_cnt == '0);
    cmd.rd_last_col = last_col;
    cmd.rd_last_row = last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows      <= CFG_W'(1);
      num_cols      <= CFG_W'(1);
      vector_length <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_ROWS: num_rows      <= cfg_data;
        REG_NUM_COLS: num_cols      <= cfg_data;
        REG_VEC_LEN:  vector_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      err_tok <= 1'b0;
      row_cnt <= '0;
      col_cnt <= '0;
      nr_q    <= CW_R'(1);
      nc_q    <= CW_C'(1);
    end else begin
      err_tok <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && (func == FUNC_COMPUTE)) begin
            if (nc_clamp != vl_clamp) begin
              err_tok <= 1'b1;
            end else begin
              state   <= ST_RUN;
              row_cnt <= '0;
              col_cnt <= '0;
              nr_q    <= nr_clamp;
              nc_q    <= nc_clamp;
            end
          end
        end
        ST_RUN: begin
          if (last_col) begin
            col_cnt <= '0;
            if (last_row) begin
              state <= ST_IDLE;
            end else begin
              row_cnt <= row_cnt + RIDX_W'(1);
            end
          end else begin
            col_cnt <= col_cnt + CIDX_W'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/mvm_dp.sv
// Datapath for the matrix-vector multiply core: matrix and vector stores,
// multiplier, accumulator and result register. Depends on mvm_pkg.
module mvm_dp
  import mvm_pkg::*;
#(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cmd_t                        cmd,
  input  logic [RIDX_W-1:0]           wr_row,
  input  logic [CIDX_W-1:0]           wr_col,
  input  logic [RIDX_W-1:0]           rd_row,
  input  logic [CIDX_W-1:0]           rd_col,
  input  logic signed [VALUE_W-1:0]   value,
  output logic                        strobe,
  output logic [ROW_OUT_W-1:0]        row_index,
  output logic signed [SUM_W-1:0]     sum,
  output logic                        last,
  output logic                        size_error
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = 2 * ELEM_WIDTH;

  logic signed [ELEM_WIDTH-1:0] mat_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] vec_mem [MAX_COLS];

  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                rd_addr;
  logic signed [ELEM_WIDTH-1:0] elem;

  logic signed [ELEM_WIDTH-1:0] m_q;
  logic signed [ELEM_WIDTH-1:0] v_q;
  tag_t                         tag1;
  logic [RIDX_W-1:0]            row1;
  logic signed [PW-1:0]         prod;
  tag_t                         tag2;
  logic [RIDX_W-1:0]            row2;
  logic signed [SUM_W-1:0]      acc;
  logic signed [SUM_W-1:0]      acc_next;

  assign wr_addr = AW'(int'(wr_row) * MAX_COLS + int'(wr_col));
  assign rd_addr = AW'(int'(rd_row) * MAX_COLS + int'(rd_col));
  assign elem    = ELEM_WIDTH'(value);

  always_ff @(posedge clk) begin
    if (cmd.wr_mat) begin
      mat_mem[wr_addr] <= elem;
    end
    m_q <= mat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_vec) begin
      vec_mem[wr_col] <= elem;
    end
    v_q <= vec_mem[rd_col];
  end

  // Pipeline: read stage, product stage, accumulate and result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
    end else begin
      tag1.valid    <= cmd.rd_valid;
      tag1.first    <= cmd.rd_first;
      tag1.last_col <= cmd.rd_last_col;
      tag1.last_row <= cmd.rd_last_row;
      tag1.err      <= cmd.rd_err;
      tag2          <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    row1 <= rd_row;
    row2 <= row1;
    prod <= m_q * v_q;
  end

  assign acc_next = tag2.first ? SUM_W'(prod) : acc + SUM_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= tag2.valid && (tag2.err || tag2.last_col);
      if (tag2.valid && !tag2.err) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag2.err) begin
      row_index  <= '0;
      sum        <= '0;
      last       <= 1'b1;
      size_error <= 1'b1;
    end else begin
      row_index  <= ROW_OUT_W'(row2);
      sum        <= acc_next;
      last       <= tag2.last_row;
      size_error <= 1'b0;
    end
  end

endmodule

>>> bench/matrix_vector_multiply_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for matrix_vector_multiply_core: loads, computes and checks row sums.
// Depends on mvm_pkg for port widths, item function codes and register indexes.
module matrix_vector_multiply_core_tb;
  import mvm_pkg::*;

  // One item on the command port and one result on the result port.
  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [IDX_IN_W-1:0]       row;
    logic [IDX_IN_W-1:0]       col;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0]    row_index;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
    logic                    size_error;
  } row_sum_t;

  // The selector value that the block has no use for.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int ROWS_MAX        = MAX_ROWS_DEF;
  localparam int COLS_MAX        = MAX_COLS_DEF;
  // Once every item is taken and every row sum is back, this many idle
  // cycles cover whatever is still in flight.
  localparam int SETTLE_CYCLES   = 8;
  localparam int RAND_PHASES     = 3;
  localparam int ITEMS_PER_PHASE = 12;
  // Watchdog limit, well above the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [FUNC_W-1:0]         func = '0;
  logic [IDX_IN_W-1:0]       row = '0;
  logic [IDX_IN_W-1:0]       col = '0;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      strobe;
  logic [ROW_OUT_W-1:0]      row_index;
  logic signed [SUM_W-1:0]   sum;
  logic                      last;
  logic                      size_error;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;

  matrix_vector_multiply_core dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .row        (row),
    .col        (col),
    .value      (value),
    .strobe     (strobe),
    .row_index  (row_index),
    .sum        (sum),
    .last       (last),
    .size_error (size_error),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Items waiting for the driver, and the row sums the block still owes us.
  item_t    pending_items[$];
  row_sum_t expected_rows[$];
  int       fail_count = 0;

  // Our own copy of the stores and of the three size registers. The size
  // registers come out of reset at one.
  logic signed [VALUE_W-1:0] mat_copy [ROWS_MAX][COLS_MAX];
  logic signed [VALUE_W-1:0] vec_copy [COLS_MAX];
  logic [CFG_W-1:0]          rows_cfg = 5'd1;
  logic [CFG_W-1:0]          cols_cfg = 5'd1;
  logic [CFG_W-1:0]          vlen_cfg = 5'd1;

  // A size register is clamped when it is used: zero counts as one, and
  // anything past the store size counts as the store size.
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v, input int maxv);
    if (v == 0) return 5'd1;
    if (v > maxv) return CFG_W'(maxv);
    return v;
  endfunction

  // Applies one accepted item to our copy of the block and queues the row sums
  // it causes. A compute item whose clamped vector length differs from the
  // clamped column count yields a single error result instead of row sums.
  // Every product of two Q8.8 values is exact in 32 bits, and sixteen of them
  // fit the 36-bit sum, so plain signed arithmetic gives the exact answer.
  task automatic apply_item(input item_t it);
    logic [CFG_W-1:0]        nr;
    logic [CFG_W-1:0]        nc;
    logic [CFG_W-1:0]        vl;
    logic signed [31:0]      prod;
    logic signed [SUM_W-1:0] acc;
    row_sum_t                res;
    case (it.func)
      FUNC_WR_MAT: mat_copy[it.row][it.col] = it.value;
      FUNC_WR_VEC: vec_copy[it.col] = it.value;
      FUNC_COMPUTE: begin
        nr = clamp_size(rows_cfg, ROWS_MAX);
        nc = clamp_size(cols_cfg, COLS_MAX);
        vl = clamp_size(vlen_cfg, COLS_MAX);
        if (nc != vl) begin
          res.row_index  = '0;
          res.sum        = '0;
          res.last       = 1'b1;
          res.size_error = 1'b1;
          expected_rows.insert(expected_rows.size(), res);
        end else begin
          for (int r = 0; r < nr; r++) begin
            acc = '0;
            for (int c = 0; c < nc; c++) begin
              prod = mat_copy[r][c] * vec_copy[c];
              acc  = acc + prod;
            end
            res.row_index  = r[ROW_OUT_W-1:0];
            res.sum        = acc;
            res.last       = (r == nr - 1);
            res.size_error = 1'b0;
            expected_rows.insert(expected_rows.size(), res);
          end
        end
      end
      default: ; // The unused selector is ignored by the block.
    endcase
  endtask

  // Driver. It sends items from pending_items in bursts of random length
  // separated by random gaps; now and then a burst is long, so there are also
  // stretches with no idle cycles at all. An item stays on the port while busy
  // is high and is taken at the edge where start is high and busy is low. A
  // new item is put up at the very edge the previous one is taken, so start
  // only drops when a gap or an empty queue calls for it.
  int   burst_left = 0;
  int   gap_left = 0;
  item_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_item('{func, row, col, value});
      end
      if (!start || !busy) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          start <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          next_item = pending_items.pop_front();
          start <= 1'b1;
          func  <= next_item.func;
          row   <= next_item.row;
          col   <= next_item.col;
          value <= next_item.value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // Monitor. Results cannot be held off, so every strobe is one result taken
  // at the edge that ends its cycle. An unknown strobe counts as a result too,
  // so that it fails instead of slipping by.
  row_sum_t want;

  always @(posedge clk) begin
    if (!rst && strobe !== 1'b0) begin
      if (expected_rows.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected result: row %0d sum %0d last %b size_error %b",
                   row_index, sum, last, size_error);
        end
        fail_count++;
      end else begin
        want = expected_rows.pop_front();
        if (row_index !== want.row_index || sum !== want.sum ||
            last !== want.last || size_error !== want.size_error) begin
          if (fail_count < 10) begin
            $display("mismatch: expected row %0d sum %0d last %b size_error %b",
                     want.row_index, want.sum, want.last, want.size_error);
            $display("          got      row %0d sum %0d last %b size_error %b",
                     row_index, sum, last, size_error);
          end
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  int unsigned cycle_count = 0;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic push_item(input logic [FUNC_W-1:0] f, input logic [IDX_IN_W-1:0] r,
                           input logic [IDX_IN_W-1:0] c, input logic [VALUE_W-1:0] v);
    pending_items.insert(pending_items.size(), item_t'{f, r, c, v});
  endtask

  // Element values: mostly uniform, sometimes one of the corner values.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Writes one size register over the configuration channel and mirrors it
  // in our copy once the write has gone through.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NUM_ROWS: rows_cfg = data;
      REG_NUM_COLS: cols_cfg = data;
      REG_VEC_LEN:  vlen_cfg = data;
      default: ;
    endcase
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] nr, input logic [CFG_W-1:0] nc,
                           input logic [CFG_W-1:0] vl);
    write_reg(REG_NUM_ROWS, nr);
    write_reg(REG_NUM_COLS, nc);
    write_reg(REG_VEC_LEN, vl);
  endtask

  // Waits until every item is taken and every row sum has come back, then
  // lets the block settle so that the registers may be written safely.
  task automatic drain();
    while (pending_items.size() != 0 || start || expected_rows.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus. A compute item only ever reads store entries that were written
  // before it: the first part works on the one-by-one reset size with element
  // zero loaded, and the whole store is filled before any larger size is used.
  initial begin : stimulus
    logic [CFG_W-1:0] rc;
    logic [CFG_W-1:0] cc;
    logic [CFG_W-1:0] vc;
    logic [CFG_W-1:0] nr;
    logic [CFG_W-1:0] nc;
    int               pick;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset sizes: the largest and smallest products,
    // zero, minus one squared, the unused selector, a vector write with a
    // nonzero row field (the row is ignored), and writes outside the part of
    // the matrix in use. Compute items carry junk in their other fields.
    push_item(FUNC_WR_MAT, 4'd0, 4'd0, 16'h7fff);
    push_item(FUNC_WR_VEC, 4'd0, 4'd0, 16'h7fff);
    push_item(FUNC_COMPUTE, 4'd0, 4'd0, 16'h0000);
    push_item(FUNC_WR_MAT, 4'd0, 4'd0, 16'h8000);
    push_item(FUNC_COMPUTE, 4'd15, 4'd15, 16'hffff);
    push_item(FUNC_WR_VEC, 4'd0, 4'd0, 16'h8000);
    push_item(FUNC_COMPUTE, 4'd5, 4'd10, 16'h8000);
    push_item(FUNC_WR_MAT, 4'd0, 4'd0, 16'h0000);
    push_item(FUNC_COMPUTE, 4'd0, 4'd0, 16'h7fff);
    push_item(FUNC_WR_MAT, 4'd0, 4'd0, 16'hffff);
    push_item(FUNC_WR_VEC, 4'd0, 4'd0, 16'hffff);
    push_item(FUNC_COMPUTE, 4'd0, 4'd0, 16'h0000);
    push_item(FUNC_UNUSED, 4'd15, 4'd15, 16'hffff);
    push_item(FUNC_UNUSED, 4'd0, 4'd0, 16'h0000);
    push_item(FUNC_WR_VEC, 4'd15, 4'd0, 16'h0100);
    push_item(FUNC_WR_MAT, 4'd15, 4'd15, 16'h7fff);
    push_item(FUNC_WR_MAT, 4'd0, 4'd15, 16'h8000);
    push_item(FUNC_WR_VEC, 4'd9, 4'd15, 16'h7fff);
    push_item(FUNC_COMPUTE, 4'd15, 4'd15, 16'h8000);
    push_item(FUNC_COMPUTE, 4'd10, 4'd5, 16'h5555);
    drain();

    // Size mismatch: four rows, three columns, vector length five.
    set_sizes(5'd4, 5'd3, 5'd5);
    push_item(FUNC_COMPUTE, 4'd0, 4'd0, 16'h0000);
    push_item(FUNC_COMPUTE, 4'd15, 4'd15, 16'hffff);
    drain();

    // All registers zero: each one counts as one, so the sizes agree.
    set_sizes(5'd0, 5'd0, 5'd0);
    push_item(FUNC_COMPUTE, 4'd3, 4'd3, 16'h1234);
    drain();

    // Registers past the store size clamp to sixteen; 31 and 17 then agree.
    // Filling everything with the most negative value gives the largest sum
    // on every row; a most positive vector then gives the most negative one.
    set_sizes(5'd31, 5'd31, 5'd17);
    for (int r = 0; r < ROWS_MAX; r++) begin
      for (int c = 0; c < COLS_MAX; c++) begin
        push_item(FUNC_WR_MAT, r[IDX_IN_W-1:0], c[IDX_IN_W-1:0], 16'h8000);
      end
    end
    for (int c = 0; c < COLS_MAX; c++) begin
      push_item(FUNC_WR_VEC, 4'd0, c[IDX_IN_W-1:0], 16'h8000);
    end
    push_item(FUNC_COMPUTE, 4'd0, 4'd0, 16'h0000);
    for (int c = 0; c < COLS_MAX; c++) begin
      push_item(FUNC_WR_VEC, 4'd0, c[IDX_IN_W-1:0], 16'h7fff);
    end
    push_item(FUNC_COMPUTE, 4'd0, 4'd0, 16'h0000);
    drain();

    // Random phases. The first runs at the full size; the rest mostly use
    // small sizes, sometimes any register value, and now and then a vector
    // length that may not match. Most writes land inside the part of the
    // matrix in use, so they show up in the sums.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        rc = 5'd16;
        cc = 5'd16;
        vc = 5'd16;
      end else begin
        rc = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 31))
                                         : CFG_W'($urandom_range(1, 5));
        cc = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 31))
                                         : CFG_W'($urandom_range(1, 5));
        vc = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 31)) : cc;
      end
      set_sizes(rc, cc, vc);
      nr = clamp_size(rc, ROWS_MAX);
      nc = clamp_size(cc, COLS_MAX);
      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 15);
        if (pick < 2) begin
          push_item(FUNC_COMPUTE, IDX_IN_W'($urandom), IDX_IN_W'($urandom), VALUE_W'($urandom));
        end else if (pick == 2) begin
          push_item(FUNC_UNUSED, IDX_IN_W'($urandom), IDX_IN_W'($urandom), VALUE_W'($urandom));
        end else if (pick < 10) begin
          push_item(FUNC_WR_MAT,
                    ($urandom_range(0, 3) != 0) ? IDX_IN_W'($urandom_range(0, nr - 1))
                                                : IDX_IN_W'($urandom),
                    ($urandom_range(0, 3) != 0) ? IDX_IN_W'($urandom_range(0, nc - 1))
                                                : IDX_IN_W'($urandom),
                    pick_value());
        end else begin
          push_item(FUNC_WR_VEC, IDX_IN_W'($urandom),
                    ($urandom_range(0, 3) != 0) ? IDX_IN_W'($urandom_range(0, nc - 1))
                                                : IDX_IN_W'($urandom),
                    pick_value());
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mvm_pkg.sv
rtl/mvm_ctrl.sv
rtl/mvm_dp.sv
rtl/matrix_vector_multiply_core.sv
bench/matrix_vector_multiply_core_tb.sv
